@@ sv/mer_pkg.sv @@
// Shared types and constants for the midpoint ellipse rasterizer.
// No dependencies; every other file refers to this package by scoped names.

package mer_pkg;

    localparam int COORD_W   = 10;
    localparam int AXIS_W    = 10;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int OPA_W     = 2 * COORD_W + 2;
    localparam int OPB_W     = SQ_W;
    localparam int PROD_W    = OPA_W + OPB_W;
    localparam int DEC_W     = 48;
    localparam int CFG_IDX_W = 1;

    localparam logic [AXIS_W-1:0] AXIS_X_RESET = AXIS_W'(80);
    localparam logic [AXIS_W-1:0] AXIS_Y_RESET = AXIS_W'(50);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEMI_AXIS_X = 1'd0,
        CFG_SEMI_AXIS_Y = 1'd1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_AA,
        MUL_BB,
        MUL_SA_B,
        MUL_SA_2Y1,
        MUL_SB_2X2,
        MUL_SB_2X3,
        MUL_SA_2Y2,
        MUL_SQ_2X1,
        MUL_SB_PROD,
        MUL_SQ_Y1,
        MUL_SA_PROD,
        MUL_SA_SB,
        MUL_SA_Y,
        MUL_SB_X1
    } mul_op_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_PROD,
        ACC_D_PLUS_4P,
        ACC_ADD_4P,
        ACC_R2_TERM
    } acc_op_t;

    typedef enum logic [2:0] {
        UPD_NONE,
        UPD_RESTART,
        UPD_R1,
        UPD_SWITCH,
        UPD_R2,
        UPD_EMIT
    } upd_op_t;

    typedef struct packed {
        mul_op_t mul_op;
        acc_op_t acc_op;
        upd_op_t upd_op;
        logic    cap_sa;
        logic    cap_sb;
    } dp_cmd_t;

    typedef struct packed {
        logic walk_active;
        logic in_region_two;
        logic y_zero;
        logic stay_region_one;
    } dp_status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_A,
        ST_SQ_B,
        ST_RS_MUL,
        ST_RS_COMMIT,
        ST_R1_T1,
        ST_R1_T2,
        ST_R1_TEST,
        ST_R1_M1,
        ST_R1_M2,
        ST_R1_COMMIT,
        ST_SW_0,
        ST_SW_1,
        ST_SW_2,
        ST_SW_3,
        ST_SW_4,
        ST_SW_5,
        ST_R2_M1,
        ST_R2_M2,
        ST_R2_COMMIT,
        ST_EMIT
    } state_t;

endpackage

@@ sv/mer_channels.sv @@
// Handshake channel interfaces: step items, result points, config writes.
// Depends on mer_pkg for field widths.

interface mer_item_if;
    logic valid;
    logic ready;
    logic restart;
    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface mer_result_if;
    logic                        valid;
    logic                        ready;
    logic [mer_pkg::COORD_W-1:0] point_x;
    logic [mer_pkg::COORD_W-1:0] point_y;
    logic                        last_point;
    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input last_point,
                  output ready);
endinterface

interface mer_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mer_pkg::CFG_IDX_W-1:0] index;
    logic [mer_pkg::AXIS_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/mer_datapath.sv @@
// Datapath: axis registers, walk state, shared multiplier, accumulator, result register.
// Depends on mer_pkg; driven by mer_ctrl through dp_cmd_t.

module mer_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mer_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mer_pkg::AXIS_W-1:0]    cfg_data,
    input  mer_pkg::dp_cmd_t              cmd,
    output mer_pkg::dp_status_t           status,
    output logic [mer_pkg::COORD_W-1:0]   point_x,
    output logic [mer_pkg::COORD_W-1:0]   point_y,
    output logic                          last_point
);

    logic [mer_pkg::AXIS_W-1:0]  axis_x_reg;
    logic [mer_pkg::AXIS_W-1:0]  axis_y_reg;
    logic [mer_pkg::COORD_W-1:0] x_reg, x_next;
    logic [mer_pkg::COORD_W-1:0] y_reg, y_next;
    logic                        r2_reg, r2_next;
    logic                        active_reg, active_next;
    logic [mer_pkg::DEC_W-1:0]   d_reg, d_next;
    logic [mer_pkg::SQ_W-1:0]    sa_reg;
    logic [mer_pkg::SQ_W-1:0]    sb_reg;
    logic [mer_pkg::PROD_W-1:0]  prod_reg;
    logic [mer_pkg::DEC_W-1:0]   acc_reg, acc_next;
    logic [mer_pkg::COORD_W-1:0] out_x_reg, out_y_reg;
    logic                        out_last_reg;

    logic [mer_pkg::COORD_W-1:0] a, b;
    logic [mer_pkg::COORD_W+1:0] two_x, two_y;
    logic [mer_pkg::COORD_W:0]   x_p1;
    logic [mer_pkg::COORD_W-1:0] y_m1;
    logic [mer_pkg::OPA_W-1:0]   op_a;
    logic [mer_pkg::OPB_W-1:0]   op_b;
    logic [mer_pkg::PROD_W-1:0]  prod_next;
    logic [mer_pkg::DEC_W-1:0]   p4, p8, sa_ext, sb_ext;
    logic                        d_neg;
    logic                        emit;

    assign a      = mer_pkg::COORD_W'(axis_x_reg);
    assign b      = mer_pkg::COORD_W'(axis_y_reg);
    assign two_x  = {1'b0, x_reg, 1'b0};
    assign two_y  = {1'b0, y_reg, 1'b0};
    assign x_p1   = {1'b0, x_reg} + 1'b1;
    assign y_m1   = y_reg - 1'b1;
    assign p4     = mer_pkg::DEC_W'(prod_reg) << 2;
    assign p8     = mer_pkg::DEC_W'(prod_reg) << 3;
    assign sa_ext = mer_pkg::DEC_W'(sa_reg);
    assign sb_ext = mer_pkg::DEC_W'(sb_reg);
    assign d_neg  = d_reg[mer_pkg::DEC_W-1];

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (cmd.mul_op)
            mer_pkg::MUL_NONE:
            begin
                op_a = '0;
                op_b = '0;
            end
            mer_pkg::MUL_AA:
            begin
                op_a = mer_pkg::OPA_W'(a);
                op_b = mer_pkg::OPB_W'(a);
            end
            mer_pkg::MUL_BB:
            begin
                op_a = mer_pkg::OPA_W'(b);
                op_b = mer_pkg::OPB_W'(b);
            end
            mer_pkg::MUL_SA_B:
            begin
                op_a = mer_pkg::OPA_W'(b);
                op_b = sa_reg;
            end
            mer_pkg::MUL_SA_2Y1:
            begin
                op_a = mer_pkg::OPA_W'(two_y - 1'b1);
                op_b = sa_reg;
            end
            mer_pkg::MUL_SB_2X2:
            begin
                op_a = mer_pkg::OPA_W'(two_x + 2'd2);
                op_b = sb_reg;
            end
            mer_pkg::MUL_SB_2X3:
            begin
                op_a = mer_pkg::OPA_W'(two_x + 2'd3);
                op_b = sb_reg;
            end
            mer_pkg::MUL_SA_2Y2:
            begin
                op_a = mer_pkg::OPA_W'(two_y - 2'd2);
                op_b = sa_reg;
            end
            mer_pkg::MUL_SQ_2X1:
            begin
                op_a = mer_pkg::OPA_W'(two_x + 1'b1);
                op_b = mer_pkg::OPB_W'(two_x + 1'b1);
            end
            mer_pkg::MUL_SB_PROD:
            begin
                op_a = prod_reg[mer_pkg::OPA_W-1:0];
                op_b = sb_reg;
            end
            mer_pkg::MUL_SQ_Y1:
            begin
                op_a = mer_pkg::OPA_W'(y_m1);
                op_b = mer_pkg::OPB_W'(y_m1);
            end
            mer_pkg::MUL_SA_PROD:
            begin
                op_a = prod_reg[mer_pkg::OPA_W-1:0];
                op_b = sa_reg;
            end
            mer_pkg::MUL_SA_SB:
            begin
                op_a = mer_pkg::OPA_W'(sa_reg);
                op_b = sb_reg;
            end
            mer_pkg::MUL_SA_Y:
            begin
                op_a = mer_pkg::OPA_W'(y_reg);
                op_b = sa_reg;
            end
            mer_pkg::MUL_SB_X1:
            begin
                op_a = mer_pkg::OPA_W'(x_p1);
                op_b = sb_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_next = mer_pkg::PROD_W'(op_a) * mer_pkg::PROD_W'(op_b);

    always_comb
    begin
        acc_next = acc_reg;
        unique case (cmd.acc_op)
            mer_pkg::ACC_HOLD:      acc_next = acc_reg;
            mer_pkg::ACC_LOAD_PROD: acc_next = mer_pkg::DEC_W'(prod_reg);
            mer_pkg::ACC_D_PLUS_4P: acc_next = d_reg + p4;
            mer_pkg::ACC_ADD_4P:    acc_next = acc_reg + p4;
            mer_pkg::ACC_R2_TERM:   acc_next = p8 - (sa_ext << 3) - (sa_ext << 2);
            default:                acc_next = acc_reg;
        endcase
    end

    always_comb
    begin
        x_next      = x_reg;
        y_next      = y_reg;
        d_next      = d_reg;
        r2_next     = r2_reg;
        active_next = active_reg;
        emit        = 1'b0;
        unique case (cmd.upd_op)
            mer_pkg::UPD_NONE:
            begin
                emit = 1'b0;
            end
            mer_pkg::UPD_RESTART:
            begin
                x_next      = '0;
                y_next      = b;
                r2_next     = 1'b0;
                d_next      = (sb_ext << 2) + sa_ext - p4;
                active_next = (b != '0);
                emit        = 1'b1;
            end
            mer_pkg::UPD_R1:
            begin
                x_next = x_p1[mer_pkg::COORD_W-1:0];
                if (d_neg)
                begin
                    d_next = acc_reg;
                end
                else
                begin
                    d_next = acc_reg - p4;
                    y_next = y_m1;
                end
                active_next = active_reg && (y_next != '0);
                emit        = 1'b1;
            end
            mer_pkg::UPD_SWITCH:
            begin
                r2_next = 1'b1;
                d_next  = acc_reg - p4;
            end
            mer_pkg::UPD_R2:
            begin
                if (d_neg)
                begin
                    d_next = d_reg + p8 - acc_reg;
                    x_next = x_p1[mer_pkg::COORD_W-1:0];
                end
                else
                begin
                    d_next = d_reg - acc_reg;
                end
                y_next      = y_m1;
                active_next = active_reg && (y_next != '0);
                emit        = 1'b1;
            end
            mer_pkg::UPD_EMIT:
            begin
                active_next = active_reg && (y_reg != '0);
                emit        = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_x_reg <= mer_pkg::AXIS_X_RESET;
            axis_y_reg <= mer_pkg::AXIS_Y_RESET;
            x_reg      <= '0;
            y_reg      <= '0;
            r2_reg     <= 1'b0;
            active_reg <= 1'b0;
            d_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mer_pkg::CFG_SEMI_AXIS_X: axis_x_reg <= cfg_data;
                    mer_pkg::CFG_SEMI_AXIS_Y: axis_y_reg <= cfg_data;
                    default:                  axis_x_reg <= axis_x_reg;
                endcase
            end
            x_reg      <= x_next;
            y_reg      <= y_next;
            r2_reg     <= r2_next;
            active_reg <= active_next;
            d_reg      <= d_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_sa)
        begin
            sa_reg <= prod_reg[mer_pkg::SQ_W-1:0];
        end
        if (cmd.cap_sb)
        begin
            sb_reg <= prod_reg[mer_pkg::SQ_W-1:0];
        end
        if (cmd.mul_op != mer_pkg::MUL_NONE)
        begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
        if (emit)
        begin
            out_x_reg    <= x_next;
            out_y_reg    <= y_next;
            out_last_reg <= (y_next == '0);
        end
    end

    assign status.walk_active     = active_reg;
    assign status.in_region_two   = r2_reg;
    assign status.y_zero          = (y_reg == '0);
    assign status.stay_region_one = (y_reg != '0) && (acc_reg > mer_pkg::DEC_W'(prod_reg));

    assign point_x    = out_x_reg;
    assign point_y    = out_y_reg;
    assign last_point = out_last_reg;

endmodule

@@ sv/mer_ctrl.sv @@
// Controller: sequences the shared multiplier and accumulator per item, owns result valid.
// Depends on mer_pkg; drives mer_datapath through dp_cmd_t.

module mer_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic                item_restart,
    output logic                result_valid,
    input  logic                result_ready,
    input  mer_pkg::dp_status_t status,
    output mer_pkg::dp_cmd_t    cmd
);

    mer_pkg::state_t state_reg, state_next;
    logic            restart_reg, restart_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mer_pkg::ST_IDLE;
            restart_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            restart_reg   <= restart_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        restart_next   = restart_reg;
        out_valid_next = out_valid_reg && !result_ready;
        item_ready     = 1'b0;
        cmd.mul_op     = mer_pkg::MUL_NONE;
        cmd.acc_op     = mer_pkg::ACC_HOLD;
        cmd.upd_op     = mer_pkg::UPD_NONE;
        cmd.cap_sa     = 1'b0;
        cmd.cap_sb     = 1'b0;
        unique case (state_reg)
            mer_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    restart_next = item_restart;
                    if (item_restart || status.walk_active)
                    begin
                        state_next = mer_pkg::ST_SQ_A;
                    end
                end
            end
            mer_pkg::ST_SQ_A:
            begin
                cmd.mul_op = mer_pkg::MUL_AA;
                state_next = mer_pkg::ST_SQ_B;
            end
            mer_pkg::ST_SQ_B:
            begin
                cmd.cap_sa = 1'b1;
                cmd.mul_op = mer_pkg::MUL_BB;
                state_next = restart_reg ? mer_pkg::ST_RS_MUL : mer_pkg::ST_R1_T1;
            end
            mer_pkg::ST_RS_MUL:
            begin
                cmd.cap_sb = 1'b1;
                cmd.mul_op = mer_pkg::MUL_SA_B;
                state_next = mer_pkg::ST_RS_COMMIT;
            end
            mer_pkg::ST_RS_COMMIT:
            begin
                if (out_free)
                begin
                    cmd.upd_op     = mer_pkg::UPD_RESTART;
                    out_valid_next = 1'b1;
                    state_next     = mer_pkg::ST_IDLE;
                end
            end
            mer_pkg::ST_R1_T1:
            begin
                cmd.cap_sb = 1'b1;
                cmd.mul_op = mer_pkg::MUL_SA_2Y1;
                if (status.in_region_two)
                begin
                    state_next = status.y_zero ? mer_pkg::ST_EMIT : mer_pkg::ST_R2_M1;
                end
                else
                begin
                    state_next = mer_pkg::ST_R1_T2;
                end
            end
            mer_pkg::ST_R1_T2:
            begin
                cmd.acc_op = mer_pkg::ACC_LOAD_PROD;
                cmd.mul_op = mer_pkg::MUL_SB_2X2;
                state_next = mer_pkg::ST_R1_TEST;
            end
            mer_pkg::ST_R1_TEST:
            begin
                state_next = status.stay_region_one ? mer_pkg::ST_R1_M1 : mer_pkg::ST_SW_0;
            end
            mer_pkg::ST_R1_M1:
            begin
                cmd.mul_op = mer_pkg::MUL_SB_2X3;
                state_next = mer_pkg::ST_R1_M2;
            end
            mer_pkg::ST_R1_M2:
            begin
                cmd.acc_op = mer_pkg::ACC_D_PLUS_4P;
                cmd.mul_op = mer_pkg::MUL_SA_2Y2;
                state_next = mer_pkg::ST_R1_COMMIT;
            end
            mer_pkg::ST_R1_COMMIT:
            begin
                if (out_free)
                begin
                    cmd.upd_op     = mer_pkg::UPD_R1;
                    out_valid_next = 1'b1;
                    state_next     = mer_pkg::ST_IDLE;
                end
            end
            mer_pkg::ST_SW_0:
            begin
                cmd.mul_op = mer_pkg::MUL_SQ_2X1;
                state_next = mer_pkg::ST_SW_1;
            end
            mer_pkg::ST_SW_1:
            begin
                cmd.mul_op = mer_pkg::MUL_SB_PROD;
                state_next = mer_pkg::ST_SW_2;
            end
            mer_pkg::ST_SW_2:
            begin
                cmd.acc_op = mer_pkg::ACC_LOAD_PROD;
                cmd.mul_op = mer_pkg::MUL_SQ_Y1;
                state_next = mer_pkg::ST_SW_3;
            end
            mer_pkg::ST_SW_3:
            begin
                cmd.mul_op = mer_pkg::MUL_SA_PROD;
                state_next = mer_pkg::ST_SW_4;
            end
            mer_pkg::ST_SW_4:
            begin
                cmd.acc_op = mer_pkg::ACC_ADD_4P;
                cmd.mul_op = mer_pkg::MUL_SA_SB;
                state_next = mer_pkg::ST_SW_5;
            end
            mer_pkg::ST_SW_5:
            begin
                cmd.upd_op = mer_pkg::UPD_SWITCH;
                state_next = status.y_zero ? mer_pkg::ST_EMIT : mer_pkg::ST_R2_M1;
            end
            mer_pkg::ST_R2_M1:
            begin
                cmd.mul_op = mer_pkg::MUL_SA_Y;
                state_next = mer_pkg::ST_R2_M2;
            end
            mer_pkg::ST_R2_M2:
            begin
                cmd.acc_op = mer_pkg::ACC_R2_TERM;
                cmd.mul_op = mer_pkg::MUL_SB_X1;
                state_next = mer_pkg::ST_R2_COMMIT;
            end
            mer_pkg::ST_R2_COMMIT:
            begin
                if (out_free)
                begin
                    cmd.upd_op     = mer_pkg::UPD_R2;
                    out_valid_next = 1'b1;
                    state_next     = mer_pkg::ST_IDLE;
                end
            end
            mer_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.upd_op     = mer_pkg::UPD_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = mer_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mer_pkg::ST_IDLE;
            end
        endcase
    end

    assign result_valid = out_valid_reg;

endmodule

@@ sv/midpoint_ellipse_rasterizer_core.sv @@
// Midpoint ellipse rasterizer top level: controller, datapath, channel binding.
// A new item is taken only once the last one has committed; all products use the single shared 22x20 multiplier.
// A step while no walk is active is accepted in idle and gives no result.
// Reset (rst_n low, async): idle, no walk, axes 80 and 50, result channel empty.
// Depends on mer_pkg, mer_channels, mer_ctrl, mer_datapath.

module midpoint_ellipse_rasterizer_core (
    input  logic         clk,
    input  logic         rst_n,
    mer_item_if.sink     item,
    mer_result_if.source result,
    mer_cfg_if.sink      cfg
);

    mer_pkg::dp_cmd_t    cmd;
    mer_pkg::dp_status_t status;
    logic                cfg_we;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid;

    mer_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .item_restart (item.restart),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    mer_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .cmd        (cmd),
        .status     (status),
        .point_x    (result.point_x),
        .point_y    (result.point_y),
        .last_point (result.last_point)
    );

endmodule
